@@ hw/rtl/slp_pkg.sv @@
// Shared types, constants and angle table for the quaternion slerp pipeline.
package slp_pkg;

  localparam int unsigned SQ_STEPS  = 15;
  localparam int unsigned ANG_STEPS = 16;
  localparam int unsigned DIV_STEPS = 32;

  localparam logic signed [32:0] GAIN_Q30 = 33'sd652032874;

  typedef logic [3:0] step_t;

  typedef enum logic [1:0] {
    MODE_A,
    MODE_B,
    MODE_LIN,
    MODE_SLERP
  } mode_t;

  typedef struct packed {
    logic [3:0][15:0] qa;
    logic [3:0][15:0] qb;
    logic [17:0]      t;
    mode_t            mode;
    logic             neg;
    logic [13:0]      cval;
    logic [14:0]      sroot;
  } side_t;

  typedef struct packed {
    logic [28:0] v;
    logic [29:0] r;
  } sq_t;

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [20:0] z;
  } vec_t;

  typedef struct packed {
    logic [1:0][32:0] x;
    logic [1:0][32:0] y;
    logic [1:0][20:0] z;
  } rot_t;

  typedef struct packed {
    logic [1:0][31:0] n;
    logic [1:0][14:0] rem;
    logic [1:0][31:0] q;
    logic [1:0]       sgn;
  } div_t;

  function automatic logic [15:0] atan_q16(input step_t i);
    logic [15:0] a;
    unique case (i)
      4'd0:  a = 16'd51472;
      4'd1:  a = 16'd30385;
      4'd2:  a = 16'd16055;
      4'd3:  a = 16'd8150;
      4'd4:  a = 16'd4091;
      4'd5:  a = 16'd2047;
      4'd6:  a = 16'd1024;
      4'd7:  a = 16'd512;
      4'd8:  a = 16'd256;
      4'd9:  a = 16'd128;
      4'd10: a = 16'd64;
      4'd11: a = 16'd32;
      4'd12: a = 16'd16;
      4'd13: a = 16'd8;
      4'd14: a = 16'd4;
      4'd15: a = 16'd2;
      default: a = 16'd0;
    endcase
    return a;
  endfunction

endpackage

@@ hw/rtl/slp_sqrt_cell.sv @@
// One bit-pair step of the restoring integer square root.
module slp_sqrt_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  slp_pkg::step_t idx,
  input  logic           in_vld,
  input  slp_pkg::side_t in_side,
  input  slp_pkg::sq_t   in_sq,
  input  logic           dn_ld,
  output logic           up_ld,
  output logic           out_vld,
  output slp_pkg::side_t out_side,
  output slp_pkg::sq_t   out_sq
);
  import slp_pkg::*;

  logic        vld_r;
  side_t       side_r;
  sq_t         sq_r;
  sq_t         sq_nxt;
  logic [29:0] bitv;
  logic [29:0] sum;

  always_comb begin
    bitv   = 30'd1 << (5'd28 - {idx, 1'b0});
    sum    = in_sq.r + bitv;
    sq_nxt = in_sq;
    if ({1'b0, in_sq.v} >= sum) begin
      sq_nxt.v = in_sq.v - sum[28:0];
      sq_nxt.r = (in_sq.r >> 1) + bitv;
    end else begin
      sq_nxt.r = in_sq.r >> 1;
    end
  end

  assign up_ld = !vld_r || dn_ld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_ld) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ld) begin
      side_r <= in_side;
      sq_r   <= sq_nxt;
    end
  end

  assign out_vld  = vld_r;
  assign out_side = side_r;
  assign out_sq   = sq_r;
endmodule

@@ hw/rtl/slp_vec_cell.sv @@
// One vectoring rotation step of the angle extraction.
module slp_vec_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  slp_pkg::step_t idx,
  input  logic           in_vld,
  input  slp_pkg::side_t in_side,
  input  slp_pkg::vec_t  in_vec,
  input  logic           dn_ld,
  output logic           up_ld,
  output logic           out_vld,
  output slp_pkg::side_t out_side,
  output slp_pkg::vec_t  out_vec
);
  import slp_pkg::*;

  logic               vld_r;
  side_t              side_r;
  vec_t               vec_r;
  vec_t               vec_nxt;
  logic signed [33:0] dx;
  logic signed [33:0] dy;
  logic signed [20:0] at;

  always_comb begin
    dx = in_vec.y >>> idx;
    dy = in_vec.x >>> idx;
    at = $signed({5'b0, atan_q16(idx)});
    vec_nxt = in_vec;
    if (!in_vec.y[33]) begin
      vec_nxt.x = in_vec.x + dx;
      vec_nxt.y = in_vec.y - dy;
      vec_nxt.z = in_vec.z + at;
    end else begin
      vec_nxt.x = in_vec.x - dx;
      vec_nxt.y = in_vec.y + dy;
      vec_nxt.z = in_vec.z - at;
    end
  end

  assign up_ld = !vld_r || dn_ld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_ld) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ld) begin
      side_r <= in_side;
      vec_r  <= vec_nxt;
    end
  end

  assign out_vld  = vld_r;
  assign out_side = side_r;
  assign out_vec  = vec_r;
endmodule

@@ hw/rtl/slp_rot_cell.sv @@
// One rotation step of the two sine lanes.
module slp_rot_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  slp_pkg::step_t idx,
  input  logic           in_vld,
  input  slp_pkg::side_t in_side,
  input  slp_pkg::rot_t  in_rot,
  input  logic           dn_ld,
  output logic           up_ld,
  output logic           out_vld,
  output slp_pkg::side_t out_side,
  output slp_pkg::rot_t  out_rot
);
  import slp_pkg::*;

  logic               vld_r;
  side_t              side_r;
  rot_t               rot_r;
  rot_t               rot_nxt;
  logic signed [32:0] xs [2];
  logic signed [32:0] ys [2];
  logic signed [20:0] zs [2];
  logic signed [32:0] dx [2];
  logic signed [32:0] dy [2];
  logic signed [20:0] at;

  always_comb begin
    at = $signed({5'b0, atan_q16(idx)});
    rot_nxt = in_rot;
    for (int l = 0; l < 2; l++) begin
      xs[l] = $signed(in_rot.x[l]);
      ys[l] = $signed(in_rot.y[l]);
      zs[l] = $signed(in_rot.z[l]);
      dx[l] = ys[l] >>> idx;
      dy[l] = xs[l] >>> idx;
      if (!zs[l][20]) begin
        rot_nxt.x[l] = xs[l] - dx[l];
        rot_nxt.y[l] = ys[l] + dy[l];
        rot_nxt.z[l] = zs[l] - at;
      end else begin
        rot_nxt.x[l] = xs[l] + dx[l];
        rot_nxt.y[l] = ys[l] - dy[l];
        rot_nxt.z[l] = zs[l] + at;
      end
    end
  end

  assign up_ld = !vld_r || dn_ld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_ld) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ld) begin
      side_r <= in_side;
      rot_r  <= rot_nxt;
    end
  end

  assign out_vld  = vld_r;
  assign out_side = side_r;
  assign out_rot  = rot_r;
endmodule

@@ hw/rtl/slp_div_cell.sv @@
// One quotient bit of the two restoring divider lanes.
module slp_div_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_vld,
  input  slp_pkg::side_t in_side,
  input  slp_pkg::div_t  in_div,
  input  logic           dn_ld,
  output logic           up_ld,
  output logic           out_vld,
  output slp_pkg::side_t out_side,
  output slp_pkg::div_t  out_div
);
  import slp_pkg::*;

  logic        vld_r;
  side_t       side_r;
  div_t        div_r;
  div_t        div_nxt;
  logic [15:0] rr [2];
  logic [15:0] dd;
  logic [15:0] diff [2];
  logic        ge [2];

  always_comb begin
    dd = {1'b0, in_side.sroot};
    div_nxt = in_div;
    for (int l = 0; l < 2; l++) begin
      rr[l]   = {in_div.rem[l], in_div.n[l][31]};
      ge[l]   = rr[l] >= dd;
      diff[l] = rr[l] - dd;
      div_nxt.rem[l] = ge[l] ? diff[l][14:0] : rr[l][14:0];
      div_nxt.q[l]   = {in_div.q[l][30:0], ge[l]};
      div_nxt.n[l]   = {in_div.n[l][30:0], 1'b0};
    end
  end

  assign up_ld = !vld_r || dn_ld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_ld) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ld) begin
      side_r <= in_side;
      div_r  <= div_nxt;
    end
  end

  assign out_vld  = vld_r;
  assign out_side = side_r;
  assign out_div  = div_r;
endmodule

@@ hw/rtl/quaternion_slerp.sv @@
// Top level of the pipelined fixed-point quaternion slerp.
//
// Input channel: in_valid/in_stall with q0 (in_first_*), q1 (in_second_*),
// both Q2.14, and the blend factor in_blend (signed Q1.16). Each request
// yields exactly one result on out_valid/out_stall (out_x..out_w, Q2.14,
// saturated). A request is taken when valid is high and stall is low.
// The datapath is a row of 88 register stages: product, dot-product and
// 1-c*c stages, a 15-cell square root, a 16-cell angle vectoring chain,
// blend-multiply and angle-split stages, two 16-cell sine lanes, a
// magnitude stage, two 32-cell divider lanes and weight, product and
// output stages. out_valid rises when the request reaches the output stage,
// and one request is taken every cycle while in_stall is low. Each cell
// loads when empty or when its successor loads, so bubbles close up and
// in_stall only rises when all cells hold data and the receiver stalls.
// A stalled result holds its value. cfg_we writes the linear threshold
// (reset 16383); write it only while the pipeline is empty. rst_n clears
// all valid bits synchronously.
module quaternion_slerp (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [14:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_first_x,
  input  logic signed [15:0] in_first_y,
  input  logic signed [15:0] in_first_z,
  input  logic signed [15:0] in_first_w,
  input  logic signed [15:0] in_second_x,
  input  logic signed [15:0] in_second_y,
  input  logic signed [15:0] in_second_z,
  input  logic signed [15:0] in_second_w,
  input  logic signed [17:0] in_blend,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_x,
  output logic signed [15:0] out_y,
  output logic signed [15:0] out_z,
  output logic signed [15:0] out_w
);
  import slp_pkg::*;

  logic [14:0] thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= 15'd16383;
    end else if (cfg_we) begin
      thr_r <= cfg_wdata;
    end
  end

  // load enables
  logic ld_1, ld_2, ld_3, ld_m, ld_a, ld_p, ld_w, ld_r, ld_o;

  // stage 1: products
  logic               s1_vld_r;
  side_t              s1_side_r;
  logic signed [31:0] s1_p_r [4];
  side_t              s1_side_nxt;
  logic [3:0][15:0]   in_qa;
  logic [3:0][15:0]   in_qb;

  assign in_qa = {in_first_w, in_first_z, in_first_y, in_first_x};
  assign in_qb = {in_second_w, in_second_z, in_second_y, in_second_x};

  always_comb begin
    s1_side_nxt      = '0;
    s1_side_nxt.qa   = in_qa;
    s1_side_nxt.qb   = in_qb;
    s1_side_nxt.t    = in_blend;
    if (!in_blend[17] && in_blend[16]) begin
      s1_side_nxt.mode = MODE_B;
    end else if (in_blend[17] || (in_blend == '0)) begin
      s1_side_nxt.mode = MODE_A;
    end else begin
      s1_side_nxt.mode = MODE_SLERP;
    end
  end

  assign ld_1     = !s1_vld_r || ld_2;
  assign in_stall = !ld_1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (ld_1) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_1) begin
      s1_side_r <= s1_side_nxt;
      for (int k = 0; k < 4; k++) begin
        s1_p_r[k] <= $signed(in_qa[k]) * $signed(in_qb[k]);
      end
    end
  end

  // stage 2: dot product, magnitude and mode
  logic               s2_vld_r;
  side_t              s2_side_r;
  side_t              s2_side_nxt;
  logic signed [33:0] dot;
  logic signed [33:0] negd;
  logic [32:0]        mag;
  logic [18:0]        cfull;

  always_comb begin
    dot = 34'(s1_p_r[0]) + 34'(s1_p_r[1]) + 34'(s1_p_r[2]) + 34'(s1_p_r[3]);
    negd = -dot;
    mag = dot[33] ? negd[32:0] : dot[32:0];
    cfull = mag[32:14];
    s2_side_nxt = s1_side_r;
    s2_side_nxt.neg = dot[33];
    s2_side_nxt.cval = '0;
    if (s1_side_r.mode == MODE_SLERP) begin
      if ((cfull >= {4'b0, thr_r}) || (cfull >= 19'd16384)) begin
        s2_side_nxt.mode = MODE_LIN;
      end else begin
        s2_side_nxt.cval = cfull[13:0];
      end
    end
  end

  assign ld_2 = !s2_vld_r || ld_3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (ld_2) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_2) begin
      s2_side_r <= s2_side_nxt;
    end
  end

  // stage 3: 1 - c*c
  logic        s3_vld_r;
  side_t       s3_side_r;
  logic [28:0] s3_v_r;
  logic [27:0] csq;

  assign csq = s2_side_r.cval * s2_side_r.cval;

  logic sq_ld [SQ_STEPS+1];

  assign ld_3 = !s3_vld_r || sq_ld[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (ld_3) begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_3) begin
      s3_side_r <= s2_side_r;
      s3_v_r    <= 29'h1000_0000 - {1'b0, csq};
    end
  end

  // square root chain
  logic  sq_vld  [SQ_STEPS+1];
  side_t sq_side [SQ_STEPS+1];
  sq_t   sq_dat  [SQ_STEPS+1];

  assign sq_vld[0]  = s3_vld_r;
  assign sq_side[0] = s3_side_r;
  assign sq_dat[0]  = '{v: s3_v_r, r: '0};

  for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sq
    slp_sqrt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .idx      (step_t'(i)),
      .in_vld   (sq_vld[i]),
      .in_side  (sq_side[i]),
      .in_sq    (sq_dat[i]),
      .dn_ld    (sq_ld[i+1]),
      .up_ld    (sq_ld[i]),
      .out_vld  (sq_vld[i+1]),
      .out_side (sq_side[i+1]),
      .out_sq   (sq_dat[i+1])
    );
  end

  // angle vectoring chain
  logic  vc_vld  [ANG_STEPS+1];
  side_t vc_side [ANG_STEPS+1];
  vec_t  vc_dat  [ANG_STEPS+1];
  logic  vc_ld   [ANG_STEPS+1];
  side_t vc_side0;

  always_comb begin
    vc_side0       = sq_side[SQ_STEPS];
    vc_side0.sroot = sq_dat[SQ_STEPS].r[14:0];
  end

  assign sq_ld[SQ_STEPS] = vc_ld[0];
  assign vc_vld[0]  = sq_vld[SQ_STEPS];
  assign vc_side[0] = vc_side0;
  assign vc_dat[0]  = '{x: $signed({4'b0, sq_side[SQ_STEPS].cval, 16'b0}),
                        y: $signed({3'b0, sq_dat[SQ_STEPS].r[14:0], 16'b0}),
                        z: '0};

  for (genvar i = 0; i < ANG_STEPS; i++) begin : g_vc
    slp_vec_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .idx      (step_t'(i)),
      .in_vld   (vc_vld[i]),
      .in_side  (vc_side[i]),
      .in_vec   (vc_dat[i]),
      .dn_ld    (vc_ld[i+1]),
      .up_ld    (vc_ld[i]),
      .out_vld  (vc_vld[i+1]),
      .out_side (vc_side[i+1]),
      .out_vec  (vc_dat[i+1])
    );
  end

  assign vc_ld[ANG_STEPS] = ld_m;

  // blend times angle
  logic               m_vld_r;
  side_t              m_side_r;
  logic signed [38:0] m_prod_r;
  logic signed [20:0] m_theta_r;

  assign ld_m = !m_vld_r || ld_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else if (ld_m) begin
      m_vld_r <= vc_vld[ANG_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (ld_m) begin
      m_side_r  <= vc_side[ANG_STEPS];
      m_theta_r <= vc_dat[ANG_STEPS].z;
      m_prod_r  <= $signed(vc_side[ANG_STEPS].t) * vc_dat[ANG_STEPS].z;
    end
  end

  // split angle
  logic               a_vld_r;
  side_t              a_side_r;
  logic signed [20:0] a_z0_r;
  logic signed [20:0] a_z1_r;
  logic signed [20:0] a1;
  logic               rt_ld [ANG_STEPS+1];

  assign a1   = m_prod_r[36:16];
  assign ld_a = !a_vld_r || rt_ld[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (ld_a) begin
      a_vld_r <= m_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_a) begin
      a_side_r <= m_side_r;
      a_z1_r   <= a1;
      a_z0_r   <= m_theta_r - a1;
    end
  end

  // sine lanes
  logic  rt_vld  [ANG_STEPS+1];
  side_t rt_side [ANG_STEPS+1];
  rot_t  rt_dat  [ANG_STEPS+1];

  assign rt_vld[0]  = a_vld_r;
  assign rt_side[0] = a_side_r;
  assign rt_dat[0]  = '{x: {GAIN_Q30, GAIN_Q30}, y: '0, z: {a_z1_r, a_z0_r}};

  for (genvar i = 0; i < ANG_STEPS; i++) begin : g_rt
    slp_rot_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .idx      (step_t'(i)),
      .in_vld   (rt_vld[i]),
      .in_side  (rt_side[i]),
      .in_rot   (rt_dat[i]),
      .dn_ld    (rt_ld[i+1]),
      .up_ld    (rt_ld[i]),
      .out_vld  (rt_vld[i+1]),
      .out_side (rt_side[i+1]),
      .out_rot  (rt_dat[i+1])
    );
  end

  assign rt_ld[ANG_STEPS] = ld_p;

  // dividend magnitude
  logic               p_vld_r;
  side_t              p_side_r;
  div_t               p_div_r;
  div_t               p_div_nxt;
  logic signed [32:0] py [2];
  logic signed [32:0] pn [2];
  logic               dv_ld [DIV_STEPS+1];

  always_comb begin
    p_div_nxt = '0;
    for (int l = 0; l < 2; l++) begin
      py[l] = $signed(rt_dat[ANG_STEPS].y[l]);
      pn[l] = -py[l];
      p_div_nxt.sgn[l] = py[l][32];
      p_div_nxt.n[l]   = py[l][32] ? pn[l][31:0] : py[l][31:0];
    end
  end

  assign ld_p = !p_vld_r || dv_ld[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
    end else if (ld_p) begin
      p_vld_r <= rt_vld[ANG_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (ld_p) begin
      p_side_r <= rt_side[ANG_STEPS];
      p_div_r  <= p_div_nxt;
    end
  end

  // divider lanes
  logic  dv_vld  [DIV_STEPS+1];
  side_t dv_side [DIV_STEPS+1];
  div_t  dv_dat  [DIV_STEPS+1];

  assign dv_vld[0]  = p_vld_r;
  assign dv_side[0] = p_side_r;
  assign dv_dat[0]  = p_div_r;

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_dv
    slp_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_vld   (dv_vld[i]),
      .in_side  (dv_side[i]),
      .in_div   (dv_dat[i]),
      .dn_ld    (dv_ld[i+1]),
      .up_ld    (dv_ld[i]),
      .out_vld  (dv_vld[i+1]),
      .out_side (dv_side[i+1]),
      .out_div  (dv_dat[i+1])
    );
  end

  assign dv_ld[DIV_STEPS] = ld_w;

  // weights
  logic               w_vld_r;
  side_t              w_side_r;
  logic signed [25:0] w_w0_r;
  logic signed [25:0] w_w1_r;
  logic signed [25:0] w0_nxt;
  logic signed [25:0] w1_nxt;
  logic signed [25:0] q0m;
  logic signed [25:0] q1m;
  logic signed [25:0] tw;
  side_t              dv_last;

  always_comb begin
    dv_last = dv_side[DIV_STEPS];
    q0m = $signed({1'b0, dv_dat[DIV_STEPS].q[0][24:0]});
    q1m = $signed({1'b0, dv_dat[DIV_STEPS].q[1][24:0]});
    tw  = 26'($signed(dv_last.t));
    if (dv_last.mode == MODE_SLERP) begin
      w0_nxt = dv_dat[DIV_STEPS].sgn[0] ? -q0m : q0m;
      w1_nxt = (dv_dat[DIV_STEPS].sgn[1] ^ dv_last.neg) ? -q1m : q1m;
    end else begin
      w0_nxt = 26'sd65536 - tw;
      w1_nxt = dv_last.neg ? -tw : tw;
    end
  end

  assign ld_w = !w_vld_r || ld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_vld_r <= 1'b0;
    end else if (ld_w) begin
      w_vld_r <= dv_vld[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (ld_w) begin
      w_side_r <= dv_last;
      w_w0_r   <= w0_nxt;
      w_w1_r   <= w1_nxt;
    end
  end

  // weighted components
  logic               r_vld_r;
  side_t              r_side_r;
  logic signed [41:0] r_pa_r [4];
  logic signed [41:0] r_pb_r [4];

  assign ld_r = !r_vld_r || ld_o;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_vld_r <= 1'b0;
    end else if (ld_r) begin
      r_vld_r <= w_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_r) begin
      r_side_r <= w_side_r;
      for (int k = 0; k < 4; k++) begin
        r_pa_r[k] <= w_w0_r * $signed(w_side_r.qa[k]);
        r_pb_r[k] <= w_w1_r * $signed(w_side_r.qb[k]);
      end
    end
  end

  // round, saturate, select
  logic               o_vld_r;
  logic [3:0][15:0]   o_q_r;
  logic [3:0][15:0]   o_q_nxt;
  logic signed [42:0] rs [4];
  logic signed [26:0] sh [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      rs[k] = 43'(r_pa_r[k]) + 43'(r_pb_r[k]) + 43'sd32768;
      sh[k] = rs[k][42:16];
      if (sh[k] > 27'sd32767) begin
        o_q_nxt[k] = 16'h7FFF;
      end else if (sh[k] < -27'sd32768) begin
        o_q_nxt[k] = 16'h8000;
      end else begin
        o_q_nxt[k] = sh[k][15:0];
      end
    end
    if (r_side_r.mode == MODE_A) begin
      o_q_nxt = r_side_r.qa;
    end else if (r_side_r.mode == MODE_B) begin
      o_q_nxt = r_side_r.qb;
    end
  end

  assign ld_o = !o_vld_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
    end else if (ld_o) begin
      o_vld_r <= r_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_o) begin
      o_q_r <= o_q_nxt;
    end
  end

  assign out_valid = o_vld_r;
  assign out_x     = $signed(o_q_r[0]);
  assign out_y     = $signed(o_q_r[1]);
  assign out_z     = $signed(o_q_r[2]);
  assign out_w     = $signed(o_q_r[3]);

  a_sroot_range: assert property (@(posedge clk) disable iff (!rst_n)
    m_vld_r && (m_side_r.mode == MODE_SLERP) |-> m_side_r.sroot >= 15'd181)
    else $error("square root below its lower bound");

  a_theta_range: assert property (@(posedge clk) disable iff (!rst_n)
    m_vld_r && (m_side_r.mode == MODE_SLERP) |->
      !m_theta_r[20] && (m_theta_r < 21'sd110000))
    else $error("angle outside first quadrant");

  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    dv_vld[DIV_STEPS] && (dv_last.mode == MODE_SLERP) |->
      ({1'b0, dv_dat[DIV_STEPS].rem[0]} < {1'b0, dv_last.sroot}) &&
      ({1'b0, dv_dat[DIV_STEPS].rem[1]} < {1'b0, dv_last.sroot}))
    else $error("divider remainder not below divisor");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !o_vld_r && !s1_vld_r)
    else $error("pipeline not empty after reset");

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for quaternion_slerp: random and directed slerp requests.
`timescale 1ns / 100ps

module testbench;

  typedef struct packed {
    logic [3:0][15:0] qa;
    logic [3:0][15:0] qb;
    logic [17:0]      t;
  } request_t;

  typedef logic [3:0][15:0] quat_t;

  localparam longint ATAN_TBL [16] = '{51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
                                       256, 128, 64, 32, 16, 8, 4, 2};

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [14:0]        cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [15:0] in_first_x = '0, in_first_y = '0, in_first_z = '0, in_first_w = '0;
  logic signed [15:0] in_second_x = '0, in_second_y = '0, in_second_z = '0, in_second_w = '0;
  logic signed [17:0] in_blend = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [15:0] out_x, out_y, out_z, out_w;

  request_t pending[$];
  quat_t    expected_q[$];
  request_t cur;
  longint   thresh;
  int       cycle_cnt = 0;
  bit       failed = 1'b0;

  quaternion_slerp dut (.*);

  always #6 clk = ~clk;

  function automatic bit gap_now();
    if (cycle_cnt >= 400 && cycle_cnt < 1200) return 1'b0;
    return $urandom_range(99) < 6;
  endfunction

  function automatic longint sine_q30(longint z);
    longint x, y, dx, dy;
    x = 652032874;
    y = 0;
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_TBL[i];
      end else begin
        x += dx; y -= dy; z += ATAN_TBL[i];
      end
    end
    return y;
  endfunction

  function automatic quat_t slerp_expect(request_t r);
    longint a[4], b[4], t, dot, c, w0, w1, s, x, y, z, dx, dy, a1, v, rt, bt, acc;
    quat_t res;
    dot = 0;
    for (int k = 0; k < 4; k++) begin
      a[k] = longint'($signed(r.qa[k]));
      b[k] = longint'($signed(r.qb[k]));
      dot += a[k] * b[k];
    end
    t = longint'($signed(r.t));
    if (t >= 65536) return r.qb;
    if (t <= 0) return r.qa;
    c = (dot < 0 ? -dot : dot) >> 14;
    if (c >= thresh || c >= 16384) begin
      w0 = 65536 - t;
      w1 = t;
    end else begin
      v = (longint'(1) << 28) - c * c;
      rt = 0;
      bt = longint'(1) << 30;
      while (bt > v) bt >>= 2;
      while (bt != 0) begin
        if (v >= rt + bt) begin
          v -= rt + bt;
          rt = (rt >> 1) + bt;
        end else begin
          rt >>= 1;
        end
        bt >>= 2;
      end
      s = rt;
      x = c << 16;
      y = s << 16;
      z = 0;
      for (int i = 0; i < 16; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x += dx; y -= dy; z += ATAN_TBL[i];
        end else begin
          x -= dx; y += dy; z -= ATAN_TBL[i];
        end
      end
      a1 = (t * z) >>> 16;
      w0 = sine_q30(z - a1) / s;
      w1 = sine_q30(a1) / s;
    end
    if (dot < 0) w1 = -w1;
    for (int k = 0; k < 4; k++) begin
      acc = (w0 * a[k] + w1 * b[k] + 32768) >>> 16;
      if (acc > 32767) acc = 32767;
      if (acc < -32768) acc = -32768;
      res[k] = acc[15:0];
    end
    return res;
  endfunction

  function automatic logic [15:0] rand_comp(int mag);
    return 16'($signed($urandom_range(2 * mag)) - mag);
  endfunction

  task automatic add_request(quat_t qa, quat_t qb, logic [17:0] t);
    request_t r;
    r.qa = qa;
    r.qb = qb;
    r.t = t;
    pending.push_back(r);
  endtask

  task automatic add_random(int n);
    quat_t qa, qb;
    logic [17:0] t;
    int sel;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(9);
      for (int k = 0; k < 4; k++) qa[k] = rand_comp(8192);
      if (sel < 4) begin
        for (int k = 0; k < 4; k++) qb[k] = qa[k] + rand_comp(1 << $urandom_range(12));
        if ($urandom_range(1))
          for (int k = 0; k < 4; k++) qb[k] = -qb[k];
      end else if (sel < 8) begin
        for (int k = 0; k < 4; k++) qb[k] = rand_comp(8192);
      end else begin
        for (int k = 0; k < 4; k++) begin
          qa[k] = 16'($urandom);
          qb[k] = 16'($urandom);
        end
      end
      case ($urandom_range(9))
        0: t = 18'($urandom);
        1: t = 18'(65536 + $urandom_range(2));
        2: t = 18'(-$urandom_range(2));
        default: t = 18'($urandom_range(1, 65535));
      endcase
      add_request(qa, qb, t);
    end
  endtask

  task automatic wait_drained();
    while (pending.size() != 0 || expected_q.size() != 0 || in_valid) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic set_threshold(logic [14:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    thresh = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (rst_n) begin
      if (in_valid && !in_stall) expected_q.push_back(slerp_expect(cur));
      if (!in_valid || !in_stall) begin
        if (pending.size() != 0 && !gap_now()) begin
          cur = pending.pop_front();
          in_valid <= 1'b1;
          {in_first_w, in_first_z, in_first_y, in_first_x} <= cur.qa;
          {in_second_w, in_second_z, in_second_y, in_second_x} <= cur.qb;
          in_blend <= cur.t;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    quat_t want, got;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got = {out_w, out_z, out_y, out_x};
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          failed = 1'b1;
        end else begin
          want = expected_q.pop_front();
          for (int k = 0; k < 4; k++)
            if (want[k] !== got[k]) begin
              $display("%0t: component %0d expected %0d actual %0d", $time, k,
                       $signed(want[k]), $signed(got[k]));
              failed = 1'b1;
            end
        end
      end
      out_stall <= gap_now();
    end
  end

  initial begin
    thresh = 16383;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    add_request({16'sd16384, 16'sd0, 16'sd0, 16'sd0}, {16'sd0, 16'sd16384, 16'sd0, 16'sd0},
                18'sd65536);
    add_request({16'sd16384, 16'sd0, 16'sd0, 16'sd0}, {16'sd0, 16'sd16384, 16'sd0, 16'sd0},
                18'sd0);
    add_request({4{16'h7fff}}, {4{16'h8000}}, 18'h1ffff);
    add_request({4{16'h8000}}, {4{16'h7fff}}, 18'h20000);
    add_request({16'sd16384, 16'sd0, 16'sd0, 16'sd0}, {16'sd0, 16'sd16384, 16'sd0, 16'sd0},
                18'sd32768);
    add_request({16'sd16384, 16'sd0, 16'sd0, 16'sd0}, {16'sd16384, 16'sd0, 16'sd0, 16'sd0},
                18'sd1);
    add_request({16'sd16384, 16'sd0, 16'sd0, 16'sd0}, {-16'sd16384, 16'sd0, 16'sd0, 16'sd0},
                18'sd65535);
    add_request({16'sd11585, 16'sd11585, 16'sd0, 16'sd0}, {16'sd0, 16'sd16384, 16'sd0, 16'sd0},
                18'sd20000);
    add_request({16'sd11585, 16'sd11585, 16'sd0, 16'sd0}, {16'sd0, -16'sd16384, 16'sd0, 16'sd0},
                18'sd40000);
    add_request({4{16'h7fff}}, {4{16'h7fff}}, 18'sd30000);
    add_request({4{16'h8000}}, {4{16'h7fff}}, 18'sd30000);
    add_request({4{16'h7fff}}, {4{16'h0000}}, 18'sd50000);
    add_random(200);
    wait_drained();
    set_threshold(15'd0);
    add_random(150);
    wait_drained();
    set_threshold(15'd16384);
    add_random(200);
    wait_drained();
    set_threshold(15'h7fff);
    add_random(100);
    wait_drained();
    set_threshold(15'd12000);
    add_random(200);
    wait_drained();
    set_threshold(15'($urandom_range(16384)));
    add_random(150);
    wait_drained();
    if (!failed) begin
      $display("** quaternion_slerp: PASSED **");
    end else begin
      $display("** quaternion_slerp: FAILED **");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("** quaternion_slerp: FAILED **");
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/slp_pkg.sv
hw/rtl/slp_sqrt_cell.sv
hw/rtl/slp_vec_cell.sv
hw/rtl/slp_rot_cell.sv
hw/rtl/slp_div_cell.sv
hw/rtl/quaternion_slerp.sv
tb/testbench.sv
